>>> sv/ttcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared types and constants of the text terminal with cursor and scroll.
// ----------------------------------------------------------------------------
package ttcs_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;
  localparam int CELL_W          = 16;

  // Fixed widths of the result fields
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int POS_FIELD_W = 11;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'h07;

  // Request kinds
  localparam logic [1:0] KIND_PUT  = 2'd0;
  localparam logic [1:0] KIND_BACK = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_position;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic item_load;
    logic clear_step;
    logic phys_load;
    logic move;
    logic addr_load;
    logic cell_write;
    logic scroll_step;
    logic read_capture;
    logic result_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       clear_last;
    logic       scroll_last;
    logic       scroll_needed;
  } status_t;

endpackage

>>> sv/text_terminal_cursor_scroll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// Character-cell text terminal: screen store, cursor, line ends, scrolling.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole screen RAM to spaces with attribute
// 0x07, one cell per clock, and item_stall stays high until the sweep ends;
// color writes are taken during that time. Requests are then handled one at
// a time, each stepped by the controller around the single screen RAM port:
// a put goes through PHYS, ADDR and WRITE, a backspace through PHYS, MOVE,
// ADDR and WRITE, a cell read through PHYS, ADDR, RD1 and RD2, and an unused
// kind from PHYS straight to RES. A put that moves past the last row also
// clears the new bottom row in SCROLL. Scrolling itself costs no copy: rows
// sit in the RAM as a ring, and a base pointer names the physical row that
// shows as the top row. The result register frees the input side, so the next
// request is taken while a result still waits under result_stall; a new
// result is held back until the previous one is gone.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll #(
  parameter int COLUMNS = ttcs_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = ttcs_pkg::ROWS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              item_valid,
  output logic              item_stall,
  input  ttcs_pkg::item_t   item,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output ttcs_pkg::result_t result,
  // attribute register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  ttcs_pkg::cmd_t    cmd;
  ttcs_pkg::status_t sts;

  // Color writes land on the next clock, always accepted
  assign cfg_ready = 1'b1;

  ttcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  ttcs_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

>>> sv/ttcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttcs_ram #(
  parameter int WIDTH = ttcs_pkg::CELL_W,
  parameter int DEPTH = ttcs_pkg::ROWS_DEFAULT * ttcs_pkg::COLUMNS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ttcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_ctrl
// Sequencer: reset clear sweep, per-request step order, scroll row clear,
// result hand-off.
// ----------------------------------------------------------------------------
module ttcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  ttcs_pkg::status_t  sts,
  output ttcs_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PHYS,
    S_MOVE,
    S_ADDR,
    S_WRITE,
    S_SCROLL,
    S_RD1,
    S_RD2,
    S_RES
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   result_free;

  assign accept      = item_valid && !item_stall;
  assign result_free = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.item_load = 1'b1;
          state_next    = S_PHYS;
        end
      end
      S_PHYS: begin
        cmd.phys_load = 1'b1;
        case (sts.kind)
          ttcs_pkg::KIND_BACK: state_next = S_MOVE;
          ttcs_pkg::KIND_PUT:  state_next = S_ADDR;
          ttcs_pkg::KIND_READ: state_next = S_ADDR;
          default:             state_next = S_RES;
        endcase
      end
      S_MOVE: begin
        cmd.move   = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_load = 1'b1;
        state_next    = (sts.kind == ttcs_pkg::KIND_READ) ? S_RD1 : S_WRITE;
      end
      S_WRITE: begin
        cmd.cell_write = 1'b1;
        state_next     = sts.scroll_needed ? S_SCROLL : S_RES;
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.scroll_last) begin
          state_next = S_RES;
        end
      end
      S_RD1: begin
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.read_capture = 1'b1;
        state_next       = S_RES;
      end
      S_RES: begin
        if (result_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      item_stall   <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      item_stall <= (state_next != S_IDLE);
      if (cmd.result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/ttcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_datapath
// Cursor, row rotation, line-end table, color register, screen RAM and
// result register.
// ----------------------------------------------------------------------------
module ttcs_datapath #(
  parameter int COLUMNS = ttcs_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = ttcs_pkg::ROWS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ttcs_pkg::cmd_t     cmd,
  output ttcs_pkg::status_t  sts,
  input  ttcs_pkg::item_t    item,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  output ttcs_pkg::result_t  result
);

  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int DEPTH     = ROWS * COLUMNS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int OUT_ROW_W = ttcs_pkg::ROW_FIELD_W;
  localparam int OUT_COL_W = ttcs_pkg::COL_FIELD_W;
  localparam int OUT_POS_W = ttcs_pkg::POS_FIELD_W;
  localparam logic [ROW_W:0] ROWS_EXT = (ROW_W + 1)'(ROWS);

  ttcs_pkg::item_t item_q;
  logic [7:0]       write_attr;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] base;          // physical row holding logical row 0
  logic [ROW_W-1:0] tgt_row;
  logic [ROW_W-1:0] phys_row;
  logic [COL_W-1:0] line_end [ROWS];
  logic [ADDR_W-1:0] addr;
  logic [COL_W-1:0] col_cnt;
  logic              read_ok;
  logic              scrolled;
  logic [7:0]        cell_char;
  logic [7:0]        cell_color;

  logic              is_nl;
  logic              rd_in_range;
  logic [ROW_W-1:0]  back_row;
  logic [ROW_W-1:0]  sel_row;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys_sel;
  logic [COL_W-1:0]  sel_col;
  logic [ADDR_W-1:0] addr_calc;
  logic [ADDR_W-1:0] pos_calc;
  logic              last_col;
  logic              last_row;
  logic              wrap;
  logic [ROW_W-1:0]  base_inc;
  logic              put_item;

  logic                        mem_we;
  logic [ttcs_pkg::CELL_W-1:0] mem_wdata;
  logic [ttcs_pkg::CELL_W-1:0] mem_rdata;

  assign is_nl       = (item_q.char_code == ttcs_pkg::NEWLINE_CODE);
  assign put_item    = (item_q.kind == ttcs_pkg::KIND_PUT);
  assign rd_in_range = (int'(item_q.read_row) < ROWS) && (int'(item_q.read_col) < COLUMNS);

  // Backspace at column 0 goes up a row (row 0 stays)
  assign back_row = (cur_col == '0) ? ((cur_row != '0) ? cur_row - 1'b1 : '0) : cur_row;

  always_comb begin
    case (item_q.kind)
      ttcs_pkg::KIND_BACK: sel_row = back_row;
      ttcs_pkg::KIND_READ: sel_row = ROW_W'(item_q.read_row);
      default:             sel_row = cur_row;
    endcase
  end

  // Logical to physical row: add base, modulo ROWS
  assign row_sum  = {1'b0, sel_row} + {1'b0, base};
  assign phys_sel = (row_sum >= ROWS_EXT) ? ROW_W'(row_sum - ROWS_EXT) : ROW_W'(row_sum);

  assign sel_col   = (item_q.kind == ttcs_pkg::KIND_READ) ? COL_W'(item_q.read_col) : cur_col;
  assign addr_calc = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(sel_col);
  assign pos_calc  = ADDR_W'(cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col);

  assign last_col = (cur_col == COL_W'(COLUMNS - 1));
  assign last_row = (cur_row == ROW_W'(ROWS - 1));
  assign wrap     = is_nl || last_col;
  assign base_inc = (base == ROW_W'(ROWS - 1)) ? '0 : base + 1'b1;

  assign sts.kind          = item_q.kind;
  assign sts.clear_last    = (addr == ADDR_W'(DEPTH - 1));
  assign sts.scroll_last   = (col_cnt == COL_W'(COLUMNS - 1));
  assign sts.scroll_needed = put_item && wrap && last_row;

  // Screen RAM write source
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {write_attr, ttcs_pkg::SPACE_CODE};
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_wdata = {ttcs_pkg::RESET_COLOR, ttcs_pkg::SPACE_CODE};
    end else if (cmd.scroll_step) begin
      mem_we = 1'b1;
    end else if (cmd.cell_write) begin
      if (item_q.kind == ttcs_pkg::KIND_BACK) begin
        mem_we = 1'b1;
      end else if (put_item && !is_nl) begin
        mem_we    = 1'b1;
        mem_wdata = {write_attr, item_q.char_code};
      end
    end
  end

  ttcs_ram #(
    .WIDTH (ttcs_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (mem_wdata),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_attr <= ttcs_pkg::RESET_COLOR;
      cur_row    <= '0;
      cur_col    <= '0;
      base       <= '0;
      addr       <= '0;
      for (int i = 0; i < ROWS; i++) begin
        line_end[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        write_attr <= cfg_data;
      end
      if (cmd.clear_step || cmd.scroll_step) begin
        addr <= addr + 1'b1;
      end
      if (cmd.addr_load) begin
        addr <= addr_calc;
      end
      if (cmd.move) begin
        if (cur_col == '0) begin
          cur_row <= tgt_row;
          cur_col <= line_end[phys_row];
        end else begin
          cur_col <= cur_col - 1'b1;
        end
      end
      if (cmd.cell_write && put_item) begin
        if (wrap) begin
          line_end[phys_row] <= cur_col;
          cur_col            <= '0;
          if (last_row) begin
            // scroll: old top physical row becomes the bottom row
            base           <= base_inc;
            line_end[base] <= cur_col;
            addr           <= ADDR_W'(base) * ADDR_W'(COLUMNS);
          end else begin
            cur_row <= cur_row + 1'b1;
          end
        end else begin
          cur_col <= cur_col + 1'b1;
        end
      end
    end
  end

  // Per-request working registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_q     <= item;
      scrolled   <= 1'b0;
      cell_char  <= '0;
      cell_color <= '0;
    end
    if (cmd.phys_load) begin
      phys_row <= phys_sel;
      tgt_row  <= back_row;
    end
    if (cmd.addr_load) begin
      read_ok <= rd_in_range;
    end
    if (cmd.cell_write) begin
      col_cnt <= '0;
      if (sts.scroll_needed) begin
        scrolled <= 1'b1;
      end
    end
    if (cmd.scroll_step) begin
      col_cnt <= col_cnt + 1'b1;
    end
    if (cmd.read_capture && read_ok) begin
      cell_char  <= mem_rdata[7:0];
      cell_color <= mem_rdata[15:8];
    end
    if (cmd.result_load) begin
      result.cursor_row      <= OUT_ROW_W'(cur_row);
      result.cursor_col      <= OUT_COL_W'(cur_col);
      result.cursor_position <= OUT_POS_W'(pos_calc);
      result.scrolled        <= scrolled;
      result.cell_char       <= cell_char;
      result.cell_color      <= cell_color;
    end
  end

endmodule

>>> sv/ttcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_checker
// Port-level checks of the text terminal, bound to the top level.
// ----------------------------------------------------------------------------
module ttcs_checker #(
  parameter int COLUMNS = ttcs_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = ttcs_pkg::ROWS_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input ttcs_pkg::result_t result
);

  // position check only where the fields are wide enough
  localparam bit POS_CHECK = (ROWS <= 32) && (COLUMNS <= 128) && (ROWS * COLUMNS <= 2048);

  logic [31:0] pos_expect;
  assign pos_expect = 32'(result.cursor_row) * 32'(COLUMNS) + 32'(result.cursor_col);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("request taken while previous one still in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared with no request in work");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(result.cursor_row) < 32'(ROWS)) &&
                     (32'(result.cursor_col) < 32'(COLUMNS)))
    else $error("cursor outside the screen");

  a_cursor_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && POS_CHECK |-> result.cursor_position == pos_expect[10:0])
    else $error("cursor position does not match row and column");

endmodule

bind text_terminal_cursor_scroll ttcs_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_ttcs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

>>> verif/text_terminal_cursor_scroll_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_test
// Self-checking bench for the character-cell terminal with cursor and scroll.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests runs first: reads after reset, reads
// out of range, the unused kind, and backspace at the top-left corner. Random
// text bursts follow: short and wrapping lines, newline runs, backspace runs,
// reads and noise. They drive the cursor past the bottom row many times. A
// behavioral screen model predicts each result the table leaves untyped. The
// text color changes between phases; both handshake sides throttle at random.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_test;

  typedef ttcs_pkg::item_t   item_t;
  typedef ttcs_pkg::result_t result_t;

  localparam int COLUMNS = ttcs_pkg::COLUMNS_DEFAULT;
  localparam int ROWS    = ttcs_pkg::ROWS_DEFAULT;

  localparam logic [1:0] KIND_PUT  = ttcs_pkg::KIND_PUT;
  localparam logic [1:0] KIND_BACK = ttcs_pkg::KIND_BACK;
  localparam logic [1:0] KIND_READ = ttcs_pkg::KIND_READ;
  // Kind 3 has no function; the block only reports the cursor
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [7:0] NEWLINE_CODE = ttcs_pkg::NEWLINE_CODE;
  localparam logic [7:0] SPACE_CODE   = ttcs_pkg::SPACE_CODE;
  localparam logic [7:0] RESET_COLOR  = ttcs_pkg::RESET_COLOR;

  localparam int DIRECTED_COUNT = 26;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 100;
  // Longest step is a scrolling put; leave headroom at drains
  localparam int SETTLE_CYCLES  = 100;
  // Room for the clear sweep plus ~650 requests at their slowest,
  // taken several times over
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    item_t   req;
    logic    typed;
    result_t want;
  } directed_step_t;

  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_valid    = 1'b0;
  logic    cfg_ready;
  logic [7:0] cfg_data  = 8'h00;

  // Screen model: {attribute, character} per cell, same cell format as the block
  logic [15:0] screen_model [ROWS*COLUMNS];
  logic [6:0]  line_end_model [ROWS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  write_attr_model;

  result_t pending_results [$];
  result_t oldest;
  int      error_count   = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  directed_step_t directed_steps [DIRECTED_COUNT];

  text_terminal_cursor_scroll uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Screen after reset: spaces in the reset attribute, cursor home
  initial begin
    for (int i = 0; i < ROWS*COLUMNS; i++) screen_model[i] = {RESET_COLOR, SPACE_CODE};
    for (int i = 0; i < ROWS; i++) line_end_model[i] = '0;
    cur_row          = 0;
    cur_col          = 0;
    write_attr_model = RESET_COLOR;
  end

  // One terminal step on the model; returns the result it reports
  function automatic result_t terminal_step(item_t req);
    result_t res;
    logic    newline;
    res = '0;
    case (req.kind)
      KIND_PUT: begin
        newline = (req.char_code == NEWLINE_CODE);
        if (!newline) screen_model[cur_row*COLUMNS + cur_col] = {write_attr_model, req.char_code};
        cur_col++;
        if (cur_col == COLUMNS || newline) begin
          // line end is the column of the newline, or the last column on wrap
          line_end_model[cur_row] = 7'(cur_col - 1);
          cur_col = 0;
          cur_row++;
          if (cur_row == ROWS) begin
            cur_row--;
            // shift up; bottom line end keeps its stale value
            for (int r = 0; r < ROWS - 1; r++) begin
              for (int c = 0; c < COLUMNS; c++)
                screen_model[r*COLUMNS + c] = screen_model[(r+1)*COLUMNS + c];
              line_end_model[r] = line_end_model[r+1];
            end
            for (int c = 0; c < COLUMNS; c++)
              screen_model[(ROWS-1)*COLUMNS + c] = {write_attr_model, SPACE_CODE};
            res.scrolled = 1'b1;
          end
        end
      end
      KIND_BACK: begin
        // at column 0 go up a row (not past row 0) to its recorded end
        if (cur_col == 0) begin
          if (cur_row > 0) cur_row--;
          cur_col = int'(line_end_model[cur_row]);
        end else begin
          cur_col--;
        end
        screen_model[cur_row*COLUMNS + cur_col] = {write_attr_model, SPACE_CODE};
      end
      KIND_READ: begin
        if (req.read_row < ROWS && req.read_col < COLUMNS)
          {res.cell_color, res.cell_char} = screen_model[req.read_row*COLUMNS + req.read_col];
      end
      default: begin
      end
    endcase
    res.cursor_row      = 5'(cur_row);
    res.cursor_col      = 7'(cur_col);
    res.cursor_position = 11'(cur_row*COLUMNS + cur_col);
    return res;
  endfunction

  // Request with the given kind and character; read fields are random noise
  function automatic item_t make_request(logic [1:0] kind, logic [7:0] ch);
    item_t req;
    req.kind      = kind;
    req.char_code = ch;
    req.read_row  = 5'($urandom_range(0, 31));
    req.read_col  = 7'($urandom_range(0, 127));
    return req;
  endfunction

  // Offer one request, wait for it to be taken, then log what it should give.
  // valid stays high on exit so back-to-back requests need no extra NBA.
  task automatic send_request(item_t req, logic typed, result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = terminal_step(req);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_attr_model = value;
    cfg_valid <= 1'b0;
  endtask

  // Random text traffic in bursts, shaped like console output
  task automatic run_random(int count);
    int    issued;
    int    n;
    int    pick;
    item_t req;
    issued = 0;
    while (issued < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // short line ended by a newline
        n = $urandom_range(0, 10);
        repeat (n) send_request(make_request(KIND_PUT, 8'($urandom_range(0, 255))), 1'b0, '0);
        send_request(make_request(KIND_PUT, NEWLINE_CODE), 1'b0, '0);
        issued += n + 1;
      end else if (pick < 45) begin
        // long line, usually wraps at the right edge
        n = $urandom_range(60, 90);
        if (n > count - issued) n = count - issued;
        repeat (n) send_request(make_request(KIND_PUT, 8'($urandom_range(0, 255))), 1'b0, '0);
        issued += n;
      end else if (pick < 60) begin
        // backspace run, often crosses back into the row above
        n = $urandom_range(1, 8);
        repeat (n) send_request(make_request(KIND_BACK, 8'($urandom_range(0, 255))), 1'b0, '0);
        issued += n;
      end else if (pick < 80) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          req  = make_request(KIND_READ, 8'($urandom_range(0, 255)));
          pick = $urandom_range(0, 99);
          if (pick < 50) begin
            // around the cursor row, where text just landed
            req.read_row = 5'(cur_row);
            req.read_col = 7'($urandom_range(0, COLUMNS - 1));
          end else if (pick < 85) begin
            req.read_row = 5'($urandom_range(0, ROWS - 1));
            req.read_col = 7'($urandom_range(0, COLUMNS - 1));
          end
          // else keep the full-range fields, often out of range
          send_request(req, 1'b0, '0);
        end
        issued += n;
      end else if (pick < 90) begin
        n = $urandom_range(1, 4);
        repeat (n) send_request(make_request(KIND_PUT, NEWLINE_CODE), 1'b0, '0);
        issued += n;
      end else if (pick < 95) begin
        // noise: any kind, any field
        n = $urandom_range(1, 3);
        repeat (n)
          send_request(make_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))),
                       1'b0, '0);
        issued += n;
      end else begin
        send_request(make_request(KIND_UNUSED, 8'($urandom_range(0, 255))), 1'b0, '0);
        issued += 1;
      end
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Result side: compare each taken result with the oldest expectation,
  // then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: row %0d col %0d",
               result.cursor_row, result.cursor_col);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("cursor_row", 16'(oldest.cursor_row), 16'(result.cursor_row));
        check_field("cursor_col", 16'(oldest.cursor_col), 16'(result.cursor_col));
        check_field("cursor_position", 16'(oldest.cursor_position),
                    16'(result.cursor_position));
        check_field("scrolled", 16'(oldest.scrolled), 16'(result.scrolled));
        check_field("cell_char", 16'(oldest.cell_char), 16'(result.cell_char));
        check_field("cell_color", 16'(oldest.cell_color), 16'(result.cell_color));
      end
    end
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("text_terminal_cursor_scroll_test: done, errors");
    $finish;
  end

  initial begin
    int         send_pct_list [PHASES];
    int         recv_pct_list [PHASES];
    logic [7:0] color_list [PHASES];
    logic [7:0] phase_color;

    send_pct_list = '{35, 35, 46, 46, 0, 0};
    recv_pct_list = '{46, 46, 35, 35, 0, 0};
    color_list    = '{8'hFF, 8'h00, 8'h5A, 8'h1E, 8'hC3, RESET_COLOR};

    // Hand-picked opening sequence. Typed rows are obvious from the reset
    // screen; the rest fall to the model. Cursor starts at home.
    directed_steps = '{
      // fresh screen: spaces in attribute 0x07 at both corners
      '{'{KIND_READ, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 8'd32, 8'h07}},
      '{'{KIND_READ, 8'hFF, 5'd24, 7'd79}, 1'b1, '{5'd0, 7'd0, 11'd0, 1'b0, 8'd32, 8'h07}},
      // out-of-range reads give zero cells
      '{'{KIND_READ, 8'h00, 5'd25, 7'd0}, 1'b1, '0},
      '{'{KIND_READ, 8'h00, 5'd31, 7'd127}, 1'b1, '0},
      '{'{KIND_READ, 8'h00, 5'd0, 7'd80}, 1'b1, '0},
      // unused kind leaves everything alone
      '{'{KIND_UNUSED, 8'hFF, 5'd31, 7'd127}, 1'b1, '0},
      // backspace at home: stays at row 0, goes to line_end[0] (0)
      '{'{KIND_BACK, 8'h00, 5'd0, 7'd0}, 1'b1, '0},
      '{'{KIND_PUT, 8'h41, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd1, 11'd1, 1'b0, 8'd0, 8'd0}},
      '{'{KIND_PUT, 8'hFF, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd2, 11'd2, 1'b0, 8'd0, 8'd0}},
      '{'{KIND_PUT, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd3, 11'd3, 1'b0, 8'd0, 8'd0}},
      '{'{KIND_READ, 8'h00, 5'd0, 7'd1}, 1'b1, '{5'd0, 7'd3, 11'd3, 1'b0, 8'hFF, 8'h07}},
      // newline at column 3 records line end 3
      '{'{KIND_PUT, NEWLINE_CODE, 5'd0, 7'd0}, 1'b1,
        '{5'd1, 7'd0, 11'd80, 1'b0, 8'd0, 8'd0}},
      // backspace from column 0 jumps to that line end and blanks it
      '{'{KIND_BACK, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd3, 11'd3, 1'b0, 8'd0, 8'd0}},
      '{'{KIND_READ, 8'h00, 5'd0, 7'd3}, 1'b1, '{5'd0, 7'd3, 11'd3, 1'b0, 8'd32, 8'h07}},
      '{'{KIND_BACK, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd2, 11'd2, 1'b0, 8'd0, 8'd0}},
      '{'{KIND_BACK, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd1, 11'd1, 1'b0, 8'd0, 8'd0}},
      '{'{KIND_BACK, 8'h00, 5'd0, 7'd0}, 1'b1, '0},
      // home again, now line_end[0] is 3
      '{'{KIND_BACK, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd3, 11'd3, 1'b0, 8'd0, 8'd0}},
      '{'{KIND_READ, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd3, 11'd3, 1'b0, 8'd32, 8'h07}},
      '{'{KIND_PUT, NEWLINE_CODE, 5'd31, 7'd127}, 1'b1,
        '{5'd1, 7'd0, 11'd80, 1'b0, 8'd0, 8'd0}},
      '{'{KIND_PUT, 8'h78, 5'd0, 7'd0}, 1'b0, '0},
      '{'{KIND_READ, 8'h00, 5'd1, 7'd0}, 1'b0, '0},
      '{'{KIND_PUT, NEWLINE_CODE, 5'd0, 7'd0}, 1'b0, '0},
      '{'{KIND_READ, 8'h00, 5'd0, 7'd2}, 1'b0, '0},
      '{'{KIND_BACK, 8'h00, 5'd0, 7'd0}, 1'b0, '0},
      '{'{KIND_BACK, 8'h00, 5'd0, 7'd0}, 1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The block is still sweeping its screen here; the handshake waits it out
    send_idle_pct = send_pct_list[0];
    recv_idle_pct = recv_pct_list[0];
    for (int i = 0; i < DIRECTED_COUNT; i++)
      send_request(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      phase_color = color_list[p];
      if (p == 2 || p == 4) phase_color = 8'($urandom_range(0, 255));
      write_attribute(phase_color);
      send_idle_pct = send_pct_list[p];
      recv_idle_pct = recv_pct_list[p];
      run_random(PHASE_ITEMS / 2);
      // hold the sender off once mid-phase until the pipe is empty
      if (p == 2) drain_results();
      run_random(PHASE_ITEMS / 2);
    end

    drain_results();
    if (error_count == 0) begin
      $display("text_terminal_cursor_scroll_test: done, clean");
    end else begin
      $display("text_terminal_cursor_scroll_test: done, errors");
    end
    $finish;
  end

endmodule
